// ----- rtl/som_ring_pkg.sv -----
// ----------------------------------------------------------------------------
// som_ring_pkg
// Shared types, codes and default constants of the ring self-organising map.
// ----------------------------------------------------------------------------
package som_ring_pkg;

	localparam int unsigned DEF_MAX_UNITS  = 256;
	localparam int unsigned DEF_GAUSS_SIZE = 64;
	localparam int unsigned DEF_COORD_BITS = 18;

	localparam int unsigned UC_W      = 9;
	localparam int unsigned LR_W      = 16;
	localparam int unsigned RAD_W     = 24;
	localparam int unsigned DECAY_W   = 24;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 24;
	localparam int unsigned UIDX_W    = 8;
	localparam int unsigned BMU_W     = 8;
	localparam int unsigned DIST_W    = 38;
	localparam int unsigned WEIGHT_W  = 17;

	localparam logic [UC_W-1:0]    RST_UNIT_COUNT = 9'd256;
	localparam logic [LR_W-1:0]    RST_LEARN_RATE = 16'd32768;
	localparam logic [RAD_W-1:0]   RST_RADIUS     = 24'd4194304;
	localparam logic [DECAY_W-1:0] RST_DECAY      = 24'd16776132;

	localparam logic [CFG_IDX_W-1:0] CFG_UNIT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY      = 2'd3;

	typedef enum logic [1:0] {
		MODE_LOAD     = 2'd0,
		MODE_TRAIN    = 2'd1,
		MODE_CLASSIFY = 2'd2,
		MODE_RESTART  = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DRAIN,
		ST_DIV1,
		ST_DIV2,
		ST_PRIME,
		ST_UPDATE,
		ST_DECAY,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

	typedef struct packed {
		logic start;
		logic run;
	} wt_ctl_t;

endpackage

// ----- rtl/som_ring_cell.sv -----
// ----------------------------------------------------------------------------
// som_ring_cell
// One prototype unit of the ring: holds a coordinate pair, loads it directly
// or takes the pair of its neighbour when the ring rotates.
// ----------------------------------------------------------------------------
module som_ring_cell
	import som_ring_pkg::*;
#(
	parameter int unsigned COORD_BITS = DEF_COORD_BITS
) (
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic [COORD_BITS-1:0] next_x,
	input  logic [COORD_BITS-1:0] next_y,
	input  logic [COORD_BITS-1:0] load_x,
	input  logic [COORD_BITS-1:0] load_y,
	output logic [COORD_BITS-1:0] x,
	output logic [COORD_BITS-1:0] y
);

	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= load_x;
			y_q <= load_y;
		end else if (ctl.shift) begin
			x_q <= next_x;
			y_q <= next_y;
		end
	end

	assign x = x_q;
	assign y = y_q;

endmodule

// ----- rtl/som_ring_div.sv -----
// ----------------------------------------------------------------------------
// som_ring_div
// Restoring divider, one quotient bit per cycle, by the current radius.
// ----------------------------------------------------------------------------
module som_ring_div
	import som_ring_pkg::*;
#(
	parameter int unsigned DIVIDEND_W = 30
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [RAD_W-1:0]      divisor,
	output logic                  busy,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient,
	output logic [RAD_W-1:0]      remainder
);

	localparam int unsigned CW = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] dq_q;
	logic [RAD_W-1:0]      rem_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [RAD_W:0]        trial;

	assign trial = {rem_q, dq_q[DIVIDEND_W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, divisor}) begin
				rem_q <= RAD_W'(trial - {1'b0, divisor});
				dq_q  <= {dq_q[DIVIDEND_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[RAD_W-1:0];
				dq_q  <= {dq_q[DIVIDEND_W-2:0], 1'b0};
			end
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = dq_q;
	assign remainder = rem_q;

endmodule

// ----- rtl/som_ring_weight.sv -----
// ----------------------------------------------------------------------------
// som_ring_weight
// Neighbourhood factor generator: walks the ring index by index, tracks the
// ring distance to the winner and its scaled quotient by the radius, and
// produces the per-unit step factor, registered in w_s1 and then f_s2, behind the walk.
// ----------------------------------------------------------------------------
module som_ring_weight
	import som_ring_pkg::*;
#(
	parameter int unsigned MAX_UNITS        = DEF_MAX_UNITS,
	parameter int unsigned GAUSS_TABLE_SIZE = DEF_GAUSS_SIZE,
	parameter int unsigned DIVIDEND_W       = 30
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wt_ctl_t                      ctl,
	input  logic [$clog2(MAX_UNITS+1)-1:0] n,
	input  logic [$clog2(MAX_UNITS)-1:0] bmu,
	input  logic [$clog2(MAX_UNITS+1)-1:0] d0,
	input  logic [DIVIDEND_W-1:0]        q0,
	input  logic [RAD_W-1:0]             r0,
	input  logic [DIVIDEND_W-1:0]        cq,
	input  logic [RAD_W-1:0]             cr,
	input  logic [RAD_W-1:0]             rad,
	input  logic [LR_W-1:0]              lr,
	output logic [LR_W-1:0]              f,
	output logic                         act
);

	localparam int unsigned NW = $clog2(MAX_UNITS + 1);
	localparam int unsigned KW = $clog2(GAUSS_TABLE_SIZE);
	localparam int unsigned CW = (NW + 16 > RAD_W) ? NW + 16 : RAD_W;
	localparam longint unsigned GS2 = 64'(GAUSS_TABLE_SIZE) * 64'(GAUSS_TABLE_SIZE);

	// Gaussian exp(-(k/S)^2/2) in Q1.16 from a thirteen-term alternating series.
	function automatic logic [WEIGHT_W-1:0] gauss_at(input int unsigned k);
		logic [63:0] a;
		logic [63:0] term;
		logic [63:0] sum;
		a = ((64'(k) * 64'(k)) << 31) / GS2;
		term = 64'd1 << 32;
		sum  = term;
		term = ((term * a) >> 32) / 1;  sum = sum - term;
		term = ((term * a) >> 32) / 2;  sum = sum + term;
		term = ((term * a) >> 32) / 3;  sum = sum - term;
		term = ((term * a) >> 32) / 4;  sum = sum + term;
		term = ((term * a) >> 32) / 5;  sum = sum - term;
		term = ((term * a) >> 32) / 6;  sum = sum + term;
		term = ((term * a) >> 32) / 7;  sum = sum - term;
		term = ((term * a) >> 32) / 8;  sum = sum + term;
		term = ((term * a) >> 32) / 9;  sum = sum - term;
		term = ((term * a) >> 32) / 10; sum = sum + term;
		term = ((term * a) >> 32) / 11; sum = sum - term;
		term = ((term * a) >> 32) / 12; sum = sum + term;
		sum = (sum + 64'd32768) >> 16;
		return sum[WEIGHT_W-1:0];
	endfunction

	logic [WEIGHT_W-1:0] tab [GAUSS_TABLE_SIZE];

	for (genvar g = 0; g < GAUSS_TABLE_SIZE; g++) begin : g_tab
		localparam logic [WEIGHT_W-1:0] TAB_VAL = gauss_at(g);
		assign tab[g] = TAB_VAL;
	end

	logic [NW-1:0]         j_q;
	logic [NW-1:0]         d_q;
	logic [DIVIDEND_W-1:0] q_q;
	logic [RAD_W-1:0]      r_q;

	logic [NW-1:0]         j1;
	logic [NW-1:0]         e1;
	logic [NW-1:0]         ne1;
	logic [NW-1:0]         dn;
	logic [RAD_W:0]        r_inc;
	logic [RAD_W:0]        r_dec;

	assign j1  = j_q + 1'b1;
	assign e1  = (j1 >= NW'(bmu)) ? j1 - NW'(bmu) : NW'(bmu) - j1;
	assign ne1 = n - e1;
	assign dn  = (ne1 < e1) ? ne1 : e1;
	assign r_inc = {1'b0, r_q} + {1'b0, cr};
	assign r_dec = {1'b0, r_q} + {1'b0, rad} - {1'b0, cr};

	// The ring distance moves by at most one from index to index, so the
	// quotient d*C/radius follows by adding or removing C/radius.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
		end else if (ctl.start) begin
			j_q <= '0;
		end else if (ctl.run && (j_q < n)) begin
			j_q <= j1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			d_q <= d0;
			q_q <= q0;
			r_q <= r0;
		end else if (ctl.run && (j_q < n)) begin
			d_q <= dn;
			if (dn > d_q) begin
				if (r_inc >= {1'b0, rad}) begin
					r_q <= RAD_W'(r_inc - {1'b0, rad});
					q_q <= q_q + cq + 1'b1;
				end else begin
					r_q <= r_inc[RAD_W-1:0];
					q_q <= q_q + cq;
				end
			end else if (dn < d_q) begin
				if (r_q < cr) begin
					r_q <= r_dec[RAD_W-1:0];
					q_q <= q_q - cq - 1'b1;
				end else begin
					r_q <= r_q - cr;
					q_q <= q_q - cq;
				end
			end
		end
	end

	logic                near;
	logic [KW-1:0]       kidx;
	logic [WEIGHT_W-1:0] w_c;
	logic [WEIGHT_W-1:0] w_s1;
	logic                act_s1;
	logic [LR_W-1:0]     f_s2;
	logic                act_s2;
	logic [LR_W+WEIGHT_W-1:0] fp;

	assign near = CW'({d_q, 16'h0000}) < CW'(rad);
	assign kidx = (q_q >= DIVIDEND_W'(GAUSS_TABLE_SIZE - 1)) ?
		KW'(GAUSS_TABLE_SIZE - 1) : q_q[KW-1:0];

	always_comb begin
		if (rad == '0) begin
			w_c = (j_q == NW'(bmu)) ? WEIGHT_W'(65536) : '0;
		end else if (near) begin
			w_c = tab[kidx];
		end else begin
			w_c = '0;
		end
	end

	assign fp = (LR_W+WEIGHT_W)'(lr) * (LR_W+WEIGHT_W)'(w_s1) +
		(LR_W+WEIGHT_W)'(32768);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
			act_s2 <= 1'b0;
		end else begin
			act_s1 <= j_q < n;
			act_s2 <= act_s1;
		end
	end

	always_ff @(posedge clk) begin
		w_s1 <= w_c;
		f_s2 <= fp[LR_W+15:16];
	end

	assign f   = f_s2;
	assign act = act_s2;

endmodule

// ----- rtl/som_ring_online_update_core.sv -----
// ----------------------------------------------------------------------------
// som_ring_online_update_core
// Online self-organising map on a ring of two-dimensional prototype units.
// ----------------------------------------------------------------------------
// The units sit in a ring of MAX_UNITS cells that rotates one place per cycle
// past a shared datapath at its head, in the search and update states only.
// A load or restart item goes from the transfer to the result state and back
// to idle. A classify item takes a search rotation of MAX_UNITS places, a
// drain of the distance pipeline, delivery of the result and a return to
// idle. A training item adds, when the current radius is non-zero, two serial
// divisions, a prime of the neighbourhood pipeline, a second rotation of
// MAX_UNITS places in which each unit is moved as it passes the head, and a
// decay step. One item is worked on at a time; a finished result waits in the
// output register while the next item is taken.
// There is no clearing pass after reset: units read before they are loaded
// hold arbitrary values.
// ----------------------------------------------------------------------------
module som_ring_online_update_core
	import som_ring_pkg::*;
#(
	parameter int unsigned MAX_UNITS        = DEF_MAX_UNITS,
	parameter int unsigned GAUSS_TABLE_SIZE = DEF_GAUSS_SIZE,
	parameter int unsigned COORD_BITS       = DEF_COORD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            mode,
	input  logic [UIDX_W-1:0]     unit_index,
	input  logic [COORD_BITS-1:0] sample_x,
	input  logic [COORD_BITS-1:0] sample_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [BMU_W-1:0]      bmu_index,
	output logic [DIST_W-1:0]     bmu_distance_sq,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_data
);

	localparam int unsigned M   = MAX_UNITS;
	localparam int unsigned IW  = $clog2(M);
	localparam int unsigned NW  = $clog2(M + 1);
	localparam int unsigned CB  = COORD_BITS;
	localparam longint unsigned CSCALE = 64'd65536 * 64'(GAUSS_TABLE_SIZE);
	localparam int unsigned DVW = $clog2(64'(M / 2) * CSCALE + 64'd1);
	localparam int unsigned SW  = 2 * CB + 1;
	localparam int unsigned DW  = (SW > 64) ? 64 : SW;
	localparam logic [SW-1:0] DMAX = {SW{1'b1}} >> (SW - DW);

	state_t state_q, state_d;
	logic [NW-1:0] cnt_q, cnt_d;

	logic [UC_W-1:0]    uc_q;
	logic [LR_W-1:0]    lri_q;
	logic [RAD_W-1:0]   radi_q;
	logic [DECAY_W-1:0] decay_q;
	logic [LR_W-1:0]    lr_q;
	logic [RAD_W-1:0]   rad_q;

	mode_t         mode_q;
	logic [CB-1:0] sx_q;
	logic [CB-1:0] sy_q;

	logic in_xfer;
	assign in_ready  = state_q == ST_IDLE;
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Units in use, clamped to between two and the ring size.
	logic [NW-1:0] n;
	always_comb begin
		if (32'(uc_q) < 32'd2) begin
			n = NW'(2);
		end else if (32'(uc_q) > 32'(M)) begin
			n = NW'(M);
		end else begin
			n = NW'(uc_q);
		end
	end

	// ---------------------------------------------------------------- ring
	logic [CB-1:0] cx [M];
	logic [CB-1:0] cy [M];
	logic [CB-1:0] tail_x;
	logic [CB-1:0] tail_y;
	logic          shift;

	assign shift = (state_q == ST_SEARCH) || (state_q == ST_UPDATE);

	for (genvar i = 0; i < M; i++) begin : g_ring
		cell_ctl_t     ctl;
		logic [CB-1:0] nx;
		logic [CB-1:0] ny;
		assign ctl.shift = shift;
		assign ctl.load  = in_xfer && (mode == MODE_LOAD) &&
			(32'(unit_index) == i);
		if (i == M - 1) begin : g_tail
			assign nx = tail_x;
			assign ny = tail_y;
		end else begin : g_link
			assign nx = cx[i+1];
			assign ny = cy[i+1];
		end
		som_ring_cell #(.COORD_BITS(CB)) u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.next_x (nx),
			.next_y (ny),
			.load_x (sample_x),
			.load_y (sample_y),
			.x      (cx[i]),
			.y      (cy[i])
		);
	end

	// Head difference to the sample, shared by search and update.
	logic signed [CB:0] dfx, dfy, ndx, ndy;
	logic [CB-1:0]      adx, ady;
	logic               gex, gey;

	assign dfx = $signed({sx_q[CB-1], sx_q}) - $signed({cx[0][CB-1], cx[0]});
	assign dfy = $signed({sy_q[CB-1], sy_q}) - $signed({cy[0][CB-1], cy[0]});
	assign ndx = -dfx;
	assign ndy = -dfy;
	assign gex = !dfx[CB];
	assign gey = !dfy[CB];
	assign adx = gex ? dfx[CB-1:0] : ndx[CB-1:0];
	assign ady = gey ? dfy[CB-1:0] : ndy[CB-1:0];

	// ---------------------------------------------------------- search
	logic [CB-1:0]   ax_s1, ay_s1;
	logic [IW-1:0]   idx_s1, idx_s2;
	logic            v_s1, v_s2;
	logic [2*CB-1:0] qx_s2, qy_s2;
	logic [SW-1:0]   dsum;
	logic [DW-1:0]   dsat;
	logic [IW-1:0]   best_q;
	logic [DW-1:0]   bestd_q;

	assign dsum = SW'(qx_s2) + SW'(qy_s2);
	assign dsat = (dsum > DMAX) ? DW'(DMAX) : DW'(dsum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SEARCH) && (cnt_q < n);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1  <= adx;
		ay_s1  <= ady;
		idx_s1 <= cnt_q[IW-1:0];
		qx_s2  <= (2*CB)'(ax_s1) * (2*CB)'(ax_s1);
		qy_s2  <= (2*CB)'(ay_s1) * (2*CB)'(ay_s1);
		idx_s2 <= idx_s1;
		// Ties keep the lower index, which arrives first.
		if (v_s2 && ((idx_s2 == '0) || (dsat < bestd_q))) begin
			best_q  <= idx_s2;
			bestd_q <= dsat;
		end
	end

	// ---------------------------------------------------- division setup
	logic [NW-1:0]  ne0;
	logic [NW-1:0]  d0;
	logic           div_start;
	logic [DVW-1:0] div_dividend;
	logic           div_busy;
	logic           div_done;
	logic [DVW-1:0] div_q;
	logic [RAD_W-1:0] div_r;
	logic [DVW-1:0] cq_q;
	logic [RAD_W-1:0] cr_q;

	assign ne0 = n - NW'(best_q);
	assign d0  = (ne0 < NW'(best_q)) ? ne0 : NW'(best_q);
	assign div_dividend = (state_q == ST_DIV1) ? DVW'(d0) * DVW'(CSCALE) : DVW'(CSCALE);

	som_ring_div #(.DIVIDEND_W(DVW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (rad_q),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	always_ff @(posedge clk) begin
		if ((state_q == ST_DIV1) && div_done) begin
			cq_q <= div_q;
			cr_q <= div_r;
		end
	end

	// ---------------------------------------------------------- update
	wt_ctl_t       wt_ctl;
	logic [LR_W-1:0] wt_f;
	logic          wt_act;

	assign wt_ctl.start = (state_q == ST_PRIME) && (cnt_q == '0);
	assign wt_ctl.run   = (state_q == ST_PRIME) || (state_q == ST_UPDATE);

	som_ring_weight #(
		.MAX_UNITS        (M),
		.GAUSS_TABLE_SIZE (GAUSS_TABLE_SIZE),
		.DIVIDEND_W       (DVW)
	) u_weight (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (wt_ctl),
		.n      (n),
		.bmu    (best_q),
		.d0     (d0),
		.q0     (div_q),
		.r0     (div_r),
		.cq     (cq_q),
		.cr     (cr_q),
		.rad    (rad_q),
		.lr     (lr_q),
		.f      (wt_f),
		.act    (wt_act)
	);

	logic [CB+15:0] mpx, mpy;
	logic [CB-1:0]  mx, my;
	logic [CB:0]    nux, nuy;
	logic [CB-1:0]  upd_x, upd_y;

	assign mpx = (CB+16)'(adx) * (CB+16)'(wt_f) + (CB+16)'(32768);
	assign mpy = (CB+16)'(ady) * (CB+16)'(wt_f) + (CB+16)'(32768);
	assign mx  = mpx[CB+15:16];
	assign my  = mpy[CB+15:16];
	assign nux = gex ? {cx[0][CB-1], cx[0]} + {1'b0, mx} : {cx[0][CB-1], cx[0]} - {1'b0, mx};
	assign nuy = gey ? {cy[0][CB-1], cy[0]} + {1'b0, my} : {cy[0][CB-1], cy[0]} - {1'b0, my};
	assign upd_x = wt_act ? nux[CB-1:0] : cx[0];
	assign upd_y = wt_act ? nuy[CB-1:0] : cy[0];

	assign tail_x = (state_q == ST_UPDATE) ? upd_x : cx[0];
	assign tail_y = (state_q == ST_UPDATE) ? upd_y : cy[0];

	// ------------------------------------------------------------ control
	logic out_load;

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					cnt_d = '0;
					if ((mode == MODE_LOAD) || (mode == MODE_RESTART)) begin
						state_d = ST_RESP;
					end else begin
						state_d = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == NW'(M - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cnt_d = '0;
				if (!v_s1 && !v_s2) begin
					if (mode_q != MODE_TRAIN) begin
						state_d = ST_RESP;
					end else if (rad_q == '0) begin
						state_d = ST_PRIME;
					end else begin
						state_d   = ST_DIV1;
						div_start = 1'b1;
					end
				end
			end
			ST_DIV1: begin
				if (div_done) begin
					state_d   = ST_DIV2;
					div_start = 1'b1;
				end
			end
			ST_DIV2: begin
				cnt_d = '0;
				if (div_done) begin
					state_d = ST_PRIME;
				end
			end
			ST_PRIME: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == NW'(2)) begin
					cnt_d   = '0;
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == NW'(M - 1)) begin
					state_d = ST_DECAY;
				end
			end
			ST_DECAY: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!out_valid || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Configuration and learning schedule.
	logic [LR_W+DECAY_W-1:0]  lr_prod;
	logic [RAD_W+DECAY_W-1:0] rad_prod;

	assign lr_prod  = (LR_W+DECAY_W)'(lr_q) * (LR_W+DECAY_W)'(decay_q);
	assign rad_prod = (RAD_W+DECAY_W)'(rad_q) * (RAD_W+DECAY_W)'(decay_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uc_q    <= RST_UNIT_COUNT;
			lri_q   <= RST_LEARN_RATE;
			radi_q  <= RST_RADIUS;
			decay_q <= RST_DECAY;
			lr_q    <= RST_LEARN_RATE;
			rad_q   <= RST_RADIUS;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_UNIT_COUNT: uc_q    <= cfg_data[UC_W-1:0];
					CFG_LEARN_RATE: lri_q   <= cfg_data[LR_W-1:0];
					CFG_RADIUS:     radi_q  <= cfg_data[RAD_W-1:0];
					CFG_DECAY:      decay_q <= cfg_data[DECAY_W-1:0];
					default: begin
					end
				endcase
			end
			if (in_xfer && (mode == MODE_RESTART)) begin
				lr_q  <= lri_q;
				rad_q <= radi_q;
			end else if (state_q == ST_DECAY) begin
				lr_q  <= lr_prod[LR_W+DECAY_W-1:DECAY_W];
				rad_q <= rad_prod[RAD_W+DECAY_W-1:DECAY_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_q <= mode_t'(mode);
			sx_q   <= sample_x;
			sy_q   <= sample_y;
		end
	end

	// ------------------------------------------------------------- result
	logic                  out_valid_q;
	logic [BMU_W-1:0]      bmu_q;
	logic [DIST_W-1:0]     dist_q;
	logic [IW+BMU_W-1:0]   bmu_ext;
	logic [DW+DIST_W-1:0]  dist_ext;
	logic                  has_bmu;

	assign bmu_ext  = {{BMU_W{1'b0}}, best_q};
	assign dist_ext = {{DIST_W{1'b0}}, bestd_q};
	assign has_bmu  = (mode_q == MODE_TRAIN) || (mode_q == MODE_CLASSIFY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			bmu_q  <= has_bmu ? bmu_ext[BMU_W-1:0] : '0;
			dist_q <= has_bmu ? dist_ext[DIST_W-1:0] : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign bmu_index       = bmu_q;
	assign bmu_distance_sq = dist_q;

	// --------------------------------------------------------- assertions
	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RESP))
		else $error("result appeared outside the result state");

	a_div_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	a_factor_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> (wt_f <= lr_q))
		else $error("step factor exceeds learning rate");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q != ST_IDLE))
		else $error("accepted transfer left the sequencer idle");

endmodule
